// File: hdl/m4inv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared types and constants of the 4x4 matrix inverse block.
// ----------------------------------------------------------------------------
package m4inv_pkg;
  localparam int ElementCount = 16;
  localparam int IdxW         = 4;
  localparam int ElemW        = 16;
  localparam int CofW         = 50;
  localparam int DetW         = 50;
  localparam int QuotW        = 50;
  localparam logic signed [ElemW-1:0] Q88One = 16'sd256;
  localparam logic signed [ElemW-1:0] ValMax = 16'sh7FFF;
  localparam logic signed [ElemW-1:0] ValMin = -16'sh8000;

  // One finished result as it is presented on the output channel.
  typedef struct packed {
    logic signed [ElemW-1:0] value;
    logic [IdxW-1:0]         index;
    logic                    last;
    logic                    singular;
    logic                    saturated;
  } result_t;
endpackage

// File: hdl/matrix4_inverse_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_inverse_cofactor
// 4x4 fixed-point matrix inverse by cofactors, elements in and out in
// column-major Q8.8.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                   tuser
// in_       in   element_value[15:0]     -
// out_      out  result_value[15:0]      {saturated,singular,result_index}
//                                        (tlast = last_result)
// Elements are written to a 16-entry memory, one per cycle.
// After the sixteenth, the cofactors are formed one at a time, each from six
// terms (fetch, two multiplies, accumulate) and a write, then the determinant.
// Each result then passes through the memory read, a 50-step serial division when
// the matrix is not singular, and the output transfer, which waits while out_tready stalls.
// Throughput is set by the divider and the multiply loop.
// Input is held off (in_tready low) from the last element to the last result.
// Reset clears control state only; the memories need none.
// ----------------------------------------------------------------------------
module matrix4_inverse_cofactor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] element_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] result_value
  output logic [5:0]  out_tuser,  // [3:0] result_index, [4] singular, [5] saturated
  output logic        out_tlast
);
  import m4inv_pkg::*;

  typedef enum logic [2:0] {S_LOAD, S_COF, S_RD, S_DIV, S_OUT} state_t;
  state_t state_r;

  logic [IdxW-1:0] ld_r, k_r;
  logic signed [ElemW-1:0] mat_mem [ElementCount];
  logic signed [CofW-1:0]  cof_mem [ElementCount];
  logic signed [ElemW-1:0] mrd_r;
  logic signed [CofW-1:0]  crd_r;
  result_t                 res_r;
  logic                    ovalid_r;

  logic in_x;
  assign in_tready = (state_r == S_LOAD);
  assign in_x = in_tvalid && in_tready;

  logic [IdxW-1:0] mrd_addr, cwr_addr;
  logic cwr_en, cdone, start_cof;
  logic signed [CofW-1:0] cwr_data;
  logic signed [DetW-1:0] det;
  assign start_cof = in_x && ld_r == IdxW'(ElementCount - 1);

  always_ff @(posedge clk) begin
    if (in_x) mat_mem[ld_r] <= $signed(in_tdata);
    mrd_r <= mat_mem[mrd_addr];
    if (cwr_en) cof_mem[cwr_addr] <= cwr_data;
    crd_r <= cof_mem[k_r];
  end

  m4inv_cofactor u_cof (
    .clk, .rst_n, .start(start_cof), .mrd_addr, .mrd_data(mrd_r),
    .cwr_en, .cwr_addr, .cwr_data, .det, .done(cdone)
  );

  logic dstart, dbusy, ddone, dsat;
  logic signed [ElemW-1:0] dq;
  logic sing;
  assign sing = (det == '0);
  assign dstart = (state_r == S_RD) && !sing;

  m4inv_divider u_div (
    .clk, .rst_n, .start(dstart), .num(crd_r), .den(det),
    .busy(dbusy), .done(ddone), .quot(dq), .sat(dsat)
  );

  logic rd_wait_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      ld_r     <= '0;
      k_r      <= '0;
      ovalid_r <= 1'b0;
      rd_wait_r <= 1'b0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_LOAD: if (in_x) begin
          ld_r <= ld_r + IdxW'(1);
          if (start_cof) state_r <= S_COF;
        end
        S_COF: if (cdone) begin k_r <= '0; rd_wait_r <= 1'b1; end
          else if (rd_wait_r) begin rd_wait_r <= 1'b0; state_r <= S_RD; end
        S_RD: begin
          if (sing) begin
            res_r.value <= (k_r[1:0] == k_r[3:2]) ? Q88One : '0;
            res_r.saturated <= 1'b0;
            state_r <= S_OUT;
            ovalid_r <= 1'b1;
          end else state_r <= S_DIV;
          res_r.index <= k_r;
          res_r.last <= (k_r == IdxW'(ElementCount - 1));
          res_r.singular <= sing;
        end
        S_DIV: if (ddone) begin
          res_r.value <= dq;
          res_r.saturated <= dsat;
          ovalid_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (ovalid_r && out_tready) begin
          k_r <= k_r + IdxW'(1);
          if (res_r.last) state_r <= S_LOAD;
          else begin state_r <= S_COF; rd_wait_r <= 1'b1; end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = res_r.value;
  assign out_tuser  = {res_r.saturated, res_r.singular, res_r.index};
  assign out_tlast  = res_r.last;

  logic unused;
  assign unused = dbusy;

  a_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  a_sing_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.singular |-> !res_r.saturated)
    else $error("singular result flagged saturated");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> state_r == S_LOAD)
    else $error("no return to load");
endmodule

// File: hdl/m4inv_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_cofactor
// Cofactor engine. Reads matrix elements from the element memory and
// writes the sixteen signed cofactors to the cofactor memory, then forms
// the Q34.16 determinant. The terms are multiplied and accumulated one after another.
// ----------------------------------------------------------------------------
module m4inv_cofactor (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic [m4inv_pkg::IdxW-1:0]             mrd_addr,
  input  logic signed [m4inv_pkg::ElemW-1:0]     mrd_data,
  output logic                                   cwr_en,
  output logic [m4inv_pkg::IdxW-1:0]             cwr_addr,
  output logic signed [m4inv_pkg::CofW-1:0]      cwr_data,
  output logic signed [m4inv_pkg::DetW-1:0]      det,
  output logic                                   done
);
  import m4inv_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_MUL1, S_MUL2, S_ACC, S_DET, S_DONE} state_t;

  state_t            state_r;
  logic [IdxW-1:0]   cof_r;      // cofactor index c*4+r (inverse order)
  logic [2:0]        term_r;     // triple-product term 0..5
  logic [1:0]        fet_r;      // which of three factors is fetched
  logic signed [ElemW-1:0] f0_r, f1_r;
  logic signed [31:0]      p_r;
  logic signed [CofW-1:0]  acc_r;
  logic signed [65:0]      dacc_r;
  logic [1:0]        drow_r;
  logic [1:0]        dstep_r;
  logic signed [CofW-1:0] c0_r;
  logic signed [DetW-1:0] det_r;
  logic              wr_r;

  // Minor row/col selection: cofactor(i=c, j=r) of element store.
  logic [1:0] mi, mj;
  logic [1:0] rs0, rs1, rs2, cs0, cs1, cs2;
  logic [1:0] pr, pc;
  logic       neg;
  assign mi = cof_r[3:2];
  assign mj = cof_r[1:0];

  function automatic logic [1:0] skip(input logic [1:0] ex, input logic [1:0] n);
    logic [2:0] v;
    v = {1'b0, n};
    if (n >= ex) v = v + 3'd1;
    return v[1:0];
  endfunction

  assign rs0 = skip(mi, 2'd0); assign rs1 = skip(mi, 2'd1); assign rs2 = skip(mi, 2'd2);
  assign cs0 = skip(mj, 2'd0); assign cs1 = skip(mj, 2'd1); assign cs2 = skip(mj, 2'd2);

  // Six terms of the 3x3 determinant: permutation (p0,p1,p2) with sign.
  logic [1:0] perm [3];
  always_comb begin
    perm[0] = 2'd0; perm[1] = 2'd1; perm[2] = 2'd2; neg = 1'b0;
    case (term_r)
      3'd0: begin perm[0] = 2'd0; perm[1] = 2'd1; perm[2] = 2'd2; neg = 1'b0; end
      3'd1: begin perm[0] = 2'd0; perm[1] = 2'd2; perm[2] = 2'd1; neg = 1'b1; end
      3'd2: begin perm[0] = 2'd1; perm[1] = 2'd0; perm[2] = 2'd2; neg = 1'b1; end
      3'd3: begin perm[0] = 2'd1; perm[1] = 2'd2; perm[2] = 2'd0; neg = 1'b0; end
      3'd4: begin perm[0] = 2'd2; perm[1] = 2'd0; perm[2] = 2'd1; neg = 1'b0; end
      3'd5: begin perm[0] = 2'd2; perm[1] = 2'd1; perm[2] = 2'd0; neg = 1'b1; end
      default: ;
    endcase
    case (fet_r)
      2'd0: pr = rs0;
      2'd1: pr = rs1;
      default: pr = rs2;
    endcase
    case (perm[fet_r])
      2'd0: pc = cs0;
      2'd1: pc = cs1;
      default: pc = cs2;
    endcase
  end

  always_comb begin
    if (state_r == S_DET) mrd_addr = {2'b00, drow_r};
    else mrd_addr = {pc, pr};
  end

  logic signed [47:0] trip;
  assign trip = p_r * mrd_data;

  // The determinant product, split into two narrow multiplies.
  logic signed [65:0] dprod;
  logic signed [CofW-1:0] cof_signed;
  assign cof_signed = (mi[0] ^ mj[0]) ? -acc_r : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cof_r   <= '0;
      term_r  <= '0;
      fet_r   <= '0;
      wr_r    <= 1'b0;
      det_r   <= '0;
      drow_r  <= '0;
      dstep_r <= '0;
      acc_r   <= '0;
      dacc_r  <= '0;
    end else begin
      wr_r <= 1'b0;
      case (state_r)
        S_IDLE: if (start) begin
          state_r <= S_FETCH; cof_r <= '0; term_r <= '0; fet_r <= '0; acc_r <= '0;
        end
        // While a cofactor is written the index still points at it, so the
        // first fetch of the next cofactor waits until the write is done.
        S_FETCH: if (!wr_r) begin fet_r <= 2'd1; state_r <= S_MUL1; end
        S_MUL1: begin f0_r <= mrd_data; fet_r <= 2'd2; state_r <= S_MUL2; end
        S_MUL2: begin
          f1_r <= mrd_data;
          p_r  <= f0_r * mrd_data;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= neg ? acc_r - CofW'(trip) : acc_r + CofW'(trip);
          fet_r <= '0;
          if (term_r == 3'd5) begin
            term_r <= '0;
            wr_r <= 1'b1;
            if (cof_r == IdxW'(ElementCount - 1)) begin
              state_r <= S_DET; drow_r <= '0; dstep_r <= '0; dacc_r <= '0;
            end else state_r <= S_FETCH;
          end else begin
            term_r <= term_r + 3'd1;
            state_r <= S_FETCH;
          end
        end
        S_DET: begin
          // Step 0 presents the row address, step 1 captures the element,
          // step 2 adds the product of row r of column 0 and its cofactor.
          dstep_r <= dstep_r + 2'd1;
          if (dstep_r == 2'd2) begin
            dacc_r <= dacc_r + dprod;
            dstep_r <= '0;
            if (drow_r == 2'd3) state_r <= S_DONE;
            drow_r <= drow_r + 2'd1;
          end
        end
        S_DONE: begin
          det_r <= DetW'(dacc_r >>> 16);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (wr_r) begin
        acc_r <= '0;
        cof_r <= cof_r + IdxW'(1);
      end
    end
  end

  // Column-0 cofactors C[k][0] are stored at index k*4; keep them locally.
  logic signed [CofW-1:0] dcof_r [4];
  always_ff @(posedge clk) begin
    if (wr_r && cof_r[1:0] == 2'b00) dcof_r[cof_r[3:2]] <= cof_signed;
  end
  logic signed [CofW-1:0] dc;
  assign dc = dcof_r[drow_r];
  logic signed [15:0] de_r;
  logic signed [41:0] plo_r;
  logic signed [40:0] phi;
  always_ff @(posedge clk) begin
    if (state_r == S_DET && dstep_r == 2'd1) begin
      de_r  <= mrd_data;
      plo_r <= 42'(mrd_data) * 42'($signed({1'b0, dc[24:0]}));
    end
  end
  assign phi   = 41'(de_r) * 41'($signed(dc[CofW-1:25]));
  assign dprod = 66'(plo_r) + (66'(phi) <<< 25);

  assign cwr_en   = wr_r;
  assign cwr_addr = cof_r;
  assign cwr_data = cof_signed;
  assign det      = det_r;
  assign done     = (state_r == S_DONE);

  logic unused;
  assign unused = ^f1_r;

  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cwr_en |-> $past(state_r) == S_ACC)
    else $error("cofactor write outside accumulate");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("done held");
  a_det_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DET && !wr_r |-> cof_r == '0)
    else $error("cofactor index not wrapped");
endmodule

// File: hdl/m4inv_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_divider
// Restoring divider, one quotient bit per cycle, signed with truncation
// toward zero and clamping to 16 bits.
// ----------------------------------------------------------------------------
module m4inv_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [m4inv_pkg::CofW-1:0]  num,
  input  logic signed [m4inv_pkg::DetW-1:0]  den,
  output logic                               busy,
  output logic                               done,
  output logic signed [m4inv_pkg::ElemW-1:0] quot,
  output logic                               sat
);
  import m4inv_pkg::*;

  logic [CofW-1:0] rem_r, q_r, dvs_r;
  logic [5:0]      cnt_r;
  logic            neg_r, busy_r, done_r;

  logic [CofW:0] trial;
  logic [CofW-1:0] shifted;
  assign shifted = {rem_r[CofW-2:0], q_r[CofW-1]};
  assign trial = {1'b0, shifted} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(CofW);
        rem_r  <= '0;
        q_r    <= num[CofW-1] ? -num : num;
        dvs_r  <= den[DetW-1] ? -den : den;
        neg_r  <= num[CofW-1] ^ den[DetW-1];
      end else if (busy_r) begin
        if (!trial[CofW]) rem_r <= trial[CofW-1:0];
        else rem_r <= shifted;
        q_r <= {q_r[CofW-2:0], ~trial[CofW]};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin busy_r <= 1'b0; done_r <= 1'b1; end
      end
    end
  end

  logic big;
  assign big = |q_r[CofW-1:15];
  always_comb begin
    sat = 1'b0;
    if (neg_r) begin
      if (q_r > CofW'(32768)) begin quot = ValMin; sat = 1'b1; end
      else quot = -ElemW'(q_r);
    end else begin
      if (big) begin quot = ValMax; sat = 1'b1; end
      else quot = ElemW'(q_r);
    end
  end
  assign busy = busy_r;
  assign done = done_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("divider did not start");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy)
    else $error("done while busy");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> cnt_r == '0 || $past(start))
    else $error("count left over");
endmodule

// File: tb/matrix4_inverse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_inverse_checker
// Watches both channels of the 4x4 inverse block, predicts each inverse
// element from the loaded matrix and compares every output transfer.
// ----------------------------------------------------------------------------
module matrix4_inverse_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [5:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count
);
  import m4inv_pkg::*;

  logic signed [63:0] elements [ElementCount];
  logic [IdxW-1:0]    load_pos;
  result_t            expected_q [$];

  assign pending_count = expected_q.size();

  function automatic logic signed [63:0] elem_at(int r, int c);
    return elements[c * 4 + r];
  endfunction

  // Signed cofactor at row i, column j, exact in Q24.24.
  function automatic logic signed [63:0] cofactor_of(int i, int j);
    int                 rows [3];
    int                 cols [3];
    int                 n;
    int                 p;
    logic signed [63:0] m [3][3];
    logic signed [63:0] d;
    n = 0;
    p = 0;
    for (int k = 0; k < 4; k++) begin
      if (k != i) begin
        rows[n] = k;
        n++;
      end
      if (k != j) begin
        cols[p] = k;
        p++;
      end
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        m[a][b] = elem_at(rows[a], cols[b]);
    d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
      - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
      + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    return ((i + j) % 2 == 1) ? -d : d;
  endfunction

  task automatic predict_inverse();
    logic signed [63:0]  cof [ElementCount];
    logic signed [127:0] det_full;
    logic signed [63:0]  det;
    logic signed [63:0]  quot;
    result_t             r;
    det_full = '0;
    for (int c = 0; c < 4; c++)
      for (int rw = 0; rw < 4; rw++)
        cof[c * 4 + rw] = cofactor_of(c, rw);
    for (int rw = 0; rw < 4; rw++)
      det_full += 128'(elem_at(rw, 0)) * 128'(cof[rw * 4]);
    // Arithmetic shift floors toward minus infinity.
    det = 64'(det_full >>> 16);
    for (int k = 0; k < ElementCount; k++) begin
      r.index     = IdxW'(k);
      r.last      = (k == ElementCount - 1);
      r.singular  = (det == 0);
      r.saturated = 1'b0;
      if (det == 0) begin
        r.value = ((k % 4) == (k / 4)) ? Q88One : '0;
      end else begin
        quot = cof[k] / det;
        if (quot > 64'(ValMax)) begin
          r.value     = ValMax;
          r.saturated = 1'b1;
        end else if (quot < 64'(ValMin)) begin
          r.value     = ValMin;
          r.saturated = 1'b1;
        end else begin
          r.value = quot[15:0];
        end
      end
      expected_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      load_pos   <= '0;
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        elements[load_pos] = 64'(signed'(in_tdata));
        if (load_pos == IdxW'(ElementCount - 1)) predict_inverse();
        load_pos <= load_pos + 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata != want.value)
            report_mismatch("result_value", signed'(out_tdata), want.value);
          if (out_tuser[3:0] != want.index)
            report_mismatch("result_index", out_tuser[3:0], want.index);
          if (out_tuser[4] != want.singular)
            report_mismatch("singular", out_tuser[4], want.singular);
          if (out_tuser[5] != want.saturated)
            report_mismatch("saturated", out_tuser[5], want.saturated);
          if (out_tlast != want.last)
            report_mismatch("last_result", out_tlast, want.last);
        end
      end
    end
  end
endmodule

// File: tb/tb_matrix4_inverse_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4_inverse_cofactor
// Feeds directed and random 4x4 matrices to the inverse block with random
// gaps on both channels; the checker predicts and compares all results.
// ----------------------------------------------------------------------------
module tb_matrix4_inverse_cofactor;
  import m4inv_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int RandomMatrices = 18;

  typedef bit  bool_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [5:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending_count;
  int          idle_cycles;
  bool_t       steady;

  matrix4_inverse_cofactor dut (.*);

  matrix4_inverse_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Random receiver stalls, none while the sender is in its steady stretch.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= steady || ($urandom_range(99) >= 32);
  end

  // Cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // in_tvalid stays high after a transfer until the next gap or element.
  task automatic send_element(logic [15:0] value);
    while (!steady && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_matrix(logic [15:0] m [16]);
    for (int k = 0; k < 16; k++) send_element(m[k]);
  endtask

  // Random Q8.8 value: mostly moderate, sometimes full range or tiny.
  function automatic logic [15:0] random_element();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(32) - 16);
      default: return 16'($urandom_range(2048) - 1024);
    endcase
  endfunction

  initial begin
    logic [15:0] m [16];
    steady    = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity, then the all-zero singular matrix.
    for (int k = 0; k < 16; k++) m[k] = (k % 4 == k / 4) ? 16'd256 : 16'd0;
    send_matrix(m);
    for (int k = 0; k < 16; k++) m[k] = 16'd0;
    send_matrix(m);
    // Diagonal at the most negative and most positive values: tiny inverses.
    for (int k = 0; k < 16; k++) m[k] = (k % 4 == k / 4) ? 16'h8000 : 16'd0;
    send_matrix(m);
    for (int k = 0; k < 16; k++) m[k] = (k % 4 == k / 4) ? 16'h7FFF : 16'h0000;
    send_matrix(m);
    // Diagonal of one LSB: exact determinant nonzero but shifted to zero.
    for (int k = 0; k < 16; k++) m[k] = (k % 4 == k / 4) ? 16'd1 : 16'd0;
    send_matrix(m);
    // Small diagonal with one large entry below it: some inverses saturate.
    for (int k = 0; k < 16; k++)
      m[k] = (k % 4 == k / 4) ? 16'd16 : ((k == 1) ? 16'h8001 : 16'd0);
    send_matrix(m);

    for (int n = 0; n < RandomMatrices; n++) begin
      steady = (n >= 8 && n < 12);
      for (int k = 0; k < 16; k++) m[k] = random_element();
      // Some well-conditioned ones: strong diagonal.
      if (n % 3 == 0)
        for (int k = 0; k < 16; k += 5) m[k] = 16'($urandom_range(1024, 512));
      send_matrix(m);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: files.f
hdl/m4inv_pkg.sv
hdl/m4inv_cofactor.sv
hdl/m4inv_divider.sv
hdl/matrix4_inverse_cofactor.sv
tb/matrix4_inverse_checker.sv
tb/tb_matrix4_inverse_cofactor.sv
